/* hdl/vat_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the vertex affine transform.
// Used by every module of the block; depends on nothing.
package vat_pkg;

    localparam int COORD_W   = 32;
    localparam int FACTOR_W  = 31;
    localparam int CFG_W     = 32;
    localparam int REG_IDX_W = 3;
    localparam int LANES     = 3;

    localparam int DEF_COORD_FRAC_BITS = 16;
    localparam int DEF_TRIG_FRAC_BITS  = 30;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [FACTOR_W-1:0]       t_factor;

    typedef struct packed {
        logic                zero;
        logic                neg;
        logic [COORD_W-1:0]  mag;
    } t_ext;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POINT,
        S_RESULT,
        S_EXT_A,
        S_EXT_B,
        S_DIV,
        S_SCALE_LO,
        S_SCALE_HI,
        S_SCALE_WB
    } t_state;

    localparam logic [1:0] CMD_LOAD_LO = 2'd0;
    localparam logic [1:0] CMD_LOAD_HI = 2'd1;
    localparam logic [1:0] CMD_BEGIN   = 2'd2;
    localparam logic [1:0] CMD_POINT   = 2'd3;

    localparam logic [1:0] MODE_SCALE     = 2'd0;
    localparam logic [1:0] MODE_ROTATE    = 2'd1;
    localparam logic [1:0] MODE_TRANSLATE = 2'd2;
    localparam logic [1:0] MODE_BAD       = 2'd3;

    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_Y   = 2'd1;
    localparam logic [1:0] AXIS_Z   = 2'd2;
    localparam logic [1:0] AXIS_BAD = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_EXT = 2'd1;
    localparam logic [1:0] ST_BAD_AXIS = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_OP_MODE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_SEL   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COS_VALUE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SIN_VALUE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_AMOUNT     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MIN_SCALE  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAX_SCALE  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_MIN_FACTOR = 3'd7;

    localparam t_coord  RST_COS_VALUE  = 32'sd1073741824;
    localparam t_coord  RST_SIN_VALUE  = 32'sd0;
    localparam t_coord  RST_AMOUNT     = 32'sd0;
    localparam t_factor RST_MIN_SCALE  = 31'd6554;
    localparam t_factor RST_MAX_SCALE  = 31'd6553600;
    localparam t_factor RST_MIN_FACTOR = 31'd66;

    localparam t_coord  COORD_MAX  = 32'sh7FFFFFFF;
    localparam t_coord  COORD_MIN  = 32'sh80000000;
    localparam t_factor FACTOR_MAX = 31'h7FFFFFFF;

    function automatic t_coord sat_add(t_coord a, t_coord b);
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1]) begin
            return s[COORD_W] ? COORD_MIN : COORD_MAX;
        end
        return s[COORD_W-1:0];
    endfunction

endpackage

/* hdl/vertex_affine_transform.sv */
`timescale 1ns / 1ps
// Top level of the vertex affine transform: control, bounding box and output register.
// Depends on vat_pkg, vat_lane, vat_merge and vat_div.
//
// Usage. Each input beat carries a command and three Q16.16 coordinates; every
// accepted beat gives exactly one output beat. The input channel is i_valid with
// o_stall, the output channel o_valid with i_stall. The user must write configuration
// registers through i_cfg_we, i_cfg_index and i_cfg_data only while the block is idle;
// the block does not enforce this. Items are handled one at a time by three coordinate
// lanes, one per axis. Loads, non-scale begins and points are written into the output
// register from the S_RESULT or S_POINT state entered on acceptance.
// A scale begin passes S_EXT_A and S_EXT_B; with a positive largest extent it waits in
// S_DIV on the divider that yields one quotient bit per cycle, then passes S_SCALE_LO,
// S_SCALE_HI and S_SCALE_WB to S_RESULT, which writes the output register. A zero extent
// goes from S_EXT_B straight to S_RESULT, and a negative one skips S_DIV.
// A new beat is accepted while the previous result still waits in the output
// register; when the receiver stalls, the next result waits until it drains.
// Synchronous reset clears the bounds, returns the factor to one, disables the
// pass, restores the register defaults and empties the output register; o_stall
// is high during reset.
module vertex_affine_transform #(
    parameter int COORD_FRAC_BITS = vat_pkg::DEF_COORD_FRAC_BITS,
    parameter int TRIG_FRAC_BITS  = vat_pkg::DEF_TRIG_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_command,
    input  vat_pkg::t_coord                    i_x_in,
    input  vat_pkg::t_coord                    i_y_in,
    input  vat_pkg::t_coord                    i_z_in,
    output logic                               o_valid,
    input  logic                               i_stall,
    output vat_pkg::t_coord                    o_x_out,
    output vat_pkg::t_coord                    o_y_out,
    output vat_pkg::t_coord                    o_z_out,
    output vat_pkg::t_factor                   o_factor_out,
    output logic [1:0]                         o_status,
    input  logic                               i_cfg_we,
    input  logic [vat_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [vat_pkg::CFG_W-1:0]          i_cfg_data
);
    import vat_pkg::*;

    localparam int      DIVIDEND_W = FACTOR_W + COORD_FRAC_BITS;
    localparam t_factor FACTOR_ONE = FACTOR_W'(64'd1 << COORD_FRAC_BITS);
    localparam t_coord  TRIG_ONE   = COORD_W'(64'sd1 << TRIG_FRAC_BITS);

    function automatic t_coord clamp_trig(t_coord v);
        if (v > TRIG_ONE) begin
            return TRIG_ONE;
        end
        if (v < -TRIG_ONE) begin
            return -TRIG_ONE;
        end
        return v;
    endfunction

    t_state  r_state;
    t_state  n_state;

    logic [1:0] r_op_mode;
    logic [1:0] r_axis_sel;
    t_coord     r_cos_value;
    t_coord     r_sin_value;
    t_coord     r_amount;
    t_factor    r_min_scale;
    t_factor    r_max_scale;
    t_factor    r_min_factor;

    t_coord     r_lo [LANES];
    t_coord     r_hi [LANES];
    t_factor    r_factor;
    logic       r_pass_en;
    logic [1:0] r_status;
    logic [1:0] r_pass_mode;
    logic [1:0] r_pass_axis;
    t_coord     r_pass_amount;
    t_coord     r_pass_cos;
    t_coord     r_pass_sin;
    t_coord     r_pass_nsin;

    t_coord     r_p [LANES];
    t_factor    r_desired;

    logic       r_ovalid;
    t_coord     r_ox;
    t_coord     r_oy;
    t_coord     r_oz;
    t_factor    r_ofactor;
    logic [1:0] r_ostatus;

    logic       in_acc;
    logic       out_free;
    logic       out_load;
    logic       out_point;
    logic       div_start;
    logic       div_done;
    logic [DIVIDEND_W-1:0] div_quot;
    t_factor    quot_sat;
    t_factor    div_factor;
    t_ext       ext;
    t_coord     in_pt [LANES];
    t_coord     pt_res [LANES];
    t_coord     lane_a [LANES];
    t_coord     lane_ca [LANES];
    t_coord     lane_b [LANES];
    t_coord     lane_cb [LANES];
    t_coord     lane_res [LANES];
    logic       lane_en;
    logic       lane_trig;
    t_coord     clamp_lo;
    t_factor    clamp_des;

    assign o_stall  = !i_rst_n || (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    assign in_pt[0] = i_x_in;
    assign in_pt[1] = i_y_in;
    assign in_pt[2] = i_z_in;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        vat_lane #(
            .COORD_FRAC_BITS (COORD_FRAC_BITS),
            .TRIG_FRAC_BITS  (TRIG_FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (lane_en),
            .i_trig (lane_trig),
            .i_a    (lane_a[g]),
            .i_ca   (lane_ca[g]),
            .i_b    (lane_b[g]),
            .i_cb   (lane_cb[g]),
            .o_res  (lane_res[g])
        );
    end

    vat_merge u_merge (
        .i_clk (i_clk),
        .i_lo  (r_lo),
        .i_hi  (r_hi),
        .o_ext (ext)
    );

    vat_div #(
        .DIVIDEND_W (DIVIDEND_W),
        .DIVISOR_W  (COORD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_desired, {COORD_FRAC_BITS{1'b0}}}),
        .i_divisor  (ext.mag),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        quot_sat   = (|div_quot[DIVIDEND_W-1:FACTOR_W]) ? FACTOR_MAX : div_quot[FACTOR_W-1:0];
        div_factor = (quot_sat < r_min_factor) ? r_min_factor : quot_sat;
        clamp_lo   = (r_amount < $signed({1'b0, r_min_scale})) ? $signed({1'b0, r_min_scale})
                                                                : r_amount;
        clamp_des  = (clamp_lo > $signed({1'b0, r_max_scale})) ? r_max_scale
                                                                : clamp_lo[FACTOR_W-1:0];
    end

    always_comb begin
        n_state   = r_state;
        out_load  = 1'b0;
        out_point = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_command)
                        CMD_POINT: n_state = S_POINT;
                        CMD_BEGIN: n_state = (r_op_mode == MODE_SCALE) ? S_EXT_A : S_RESULT;
                        default:   n_state = S_RESULT;
                    endcase
                end
            end
            S_POINT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    out_point = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_EXT_A: begin
                n_state = S_EXT_B;
            end
            S_EXT_B: begin
                if (ext.zero) begin
                    n_state = S_RESULT;
                end else if (ext.neg) begin
                    n_state = S_SCALE_LO;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_SCALE_LO;
                end
            end
            S_SCALE_LO: n_state = S_SCALE_HI;
            S_SCALE_HI: n_state = S_SCALE_WB;
            S_SCALE_WB: n_state = S_RESULT;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        lane_en   = 1'b0;
        lane_trig = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            lane_a[i]  = in_pt[i];
            lane_ca[i] = {1'b0, r_factor};
            lane_b[i]  = '0;
            lane_cb[i] = '0;
        end
        case (r_state)
            S_IDLE: begin
                lane_en = in_acc && (i_command == CMD_POINT);
                if (r_pass_mode == MODE_ROTATE) begin
                    lane_trig = 1'b1;
                    for (int i = 0; i < LANES; i++) begin
                        lane_ca[i] = TRIG_ONE;
                    end
                    case (r_pass_axis)
                        AXIS_X: begin
                            lane_a[1] = i_y_in; lane_ca[1] = r_pass_cos;
                            lane_b[1] = i_z_in; lane_cb[1] = r_pass_nsin;
                            lane_a[2] = i_y_in; lane_ca[2] = r_pass_sin;
                            lane_b[2] = i_z_in; lane_cb[2] = r_pass_cos;
                        end
                        AXIS_Y: begin
                            lane_a[0] = i_x_in; lane_ca[0] = r_pass_cos;
                            lane_b[0] = i_z_in; lane_cb[0] = r_pass_sin;
                            lane_a[2] = i_x_in; lane_ca[2] = r_pass_nsin;
                            lane_b[2] = i_z_in; lane_cb[2] = r_pass_cos;
                        end
                        AXIS_Z: begin
                            lane_a[0] = i_x_in; lane_ca[0] = r_pass_cos;
                            lane_b[0] = i_y_in; lane_cb[0] = r_pass_nsin;
                            lane_a[1] = i_x_in; lane_ca[1] = r_pass_sin;
                            lane_b[1] = i_y_in; lane_cb[1] = r_pass_cos;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCALE_LO: begin
                lane_en = 1'b1;
                for (int i = 0; i < LANES; i++) begin
                    lane_a[i] = r_lo[i];
                end
            end
            S_SCALE_HI: begin
                lane_en = 1'b1;
                for (int i = 0; i < LANES; i++) begin
                    lane_a[i] = r_hi[i];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            pt_res[i] = r_p[i];
        end
        if (r_pass_en) begin
            case (r_pass_mode) inside
                MODE_SCALE, MODE_ROTATE: begin
                    for (int i = 0; i < LANES; i++) begin
                        pt_res[i] = lane_res[i];
                    end
                end
                MODE_TRANSLATE: begin
                    for (int i = 0; i < LANES; i++) begin
                        if (r_pass_axis == 2'(i)) begin
                            pt_res[i] = sat_add(r_p[i], r_pass_amount);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_op_mode     <= MODE_SCALE;
            r_axis_sel    <= AXIS_X;
            r_cos_value   <= RST_COS_VALUE;
            r_sin_value   <= RST_SIN_VALUE;
            r_amount      <= RST_AMOUNT;
            r_min_scale   <= RST_MIN_SCALE;
            r_max_scale   <= RST_MAX_SCALE;
            r_min_factor  <= RST_MIN_FACTOR;
            for (int i = 0; i < LANES; i++) begin
                r_lo[i] <= '0;
                r_hi[i] <= '0;
            end
            r_factor      <= FACTOR_ONE;
            r_pass_en     <= 1'b0;
            r_status      <= ST_OK;
            r_pass_mode   <= MODE_SCALE;
            r_pass_axis   <= AXIS_X;
            r_pass_amount <= '0;
            r_pass_cos    <= TRIG_ONE;
            r_pass_sin    <= '0;
            r_pass_nsin   <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_OP_MODE:    r_op_mode    <= i_cfg_data[1:0];
                    REG_AXIS_SEL:   r_axis_sel   <= i_cfg_data[1:0];
                    REG_COS_VALUE:  r_cos_value  <= i_cfg_data;
                    REG_SIN_VALUE:  r_sin_value  <= i_cfg_data;
                    REG_AMOUNT:     r_amount     <= i_cfg_data;
                    REG_MIN_SCALE:  r_min_scale  <= i_cfg_data[FACTOR_W-1:0];
                    REG_MAX_SCALE:  r_max_scale  <= i_cfg_data[FACTOR_W-1:0];
                    REG_MIN_FACTOR: r_min_factor <= i_cfg_data[FACTOR_W-1:0];
                endcase
            end

            if (in_acc) begin
                case (i_command)
                    CMD_LOAD_LO: begin
                        for (int i = 0; i < LANES; i++) begin
                            r_lo[i] <= in_pt[i];
                        end
                    end
                    CMD_LOAD_HI: begin
                        for (int i = 0; i < LANES; i++) begin
                            r_hi[i] <= in_pt[i];
                        end
                    end
                    CMD_BEGIN: begin
                        r_pass_mode   <= r_op_mode;
                        r_pass_axis   <= r_axis_sel;
                        r_pass_amount <= r_amount;
                        r_pass_cos    <= clamp_trig(r_cos_value);
                        r_pass_sin    <= clamp_trig(r_sin_value);
                        r_pass_nsin   <= -clamp_trig(r_sin_value);
                        if (r_op_mode != MODE_SCALE
                                && (r_op_mode == MODE_BAD || r_axis_sel == AXIS_BAD)) begin
                            r_status  <= ST_BAD_AXIS;
                            r_pass_en <= 1'b0;
                        end else begin
                            r_status  <= ST_OK;
                            r_pass_en <= 1'b1;
                        end
                        if (r_op_mode == MODE_TRANSLATE && r_axis_sel != AXIS_BAD) begin
                            for (int i = 0; i < LANES; i++) begin
                                if (r_axis_sel == 2'(i)) begin
                                    r_lo[i] <= sat_add(r_lo[i], r_amount);
                                    r_hi[i] <= sat_add(r_hi[i], r_amount);
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (r_state == S_EXT_B) begin
                if (ext.zero) begin
                    r_status  <= ST_ZERO_EXT;
                    r_pass_en <= 1'b0;
                end else if (ext.neg) begin
                    r_factor <= r_min_factor;
                end
            end
            if (r_state == S_DIV && div_done) begin
                r_factor <= div_factor;
            end
            if (r_state == S_SCALE_HI) begin
                for (int i = 0; i < LANES; i++) begin
                    r_lo[i] <= lane_res[i];
                end
            end
            if (r_state == S_SCALE_WB) begin
                for (int i = 0; i < LANES; i++) begin
                    r_hi[i] <= lane_res[i];
                end
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_command == CMD_POINT) begin
            for (int i = 0; i < LANES; i++) begin
                r_p[i] <= in_pt[i];
            end
        end
        if (in_acc && i_command == CMD_BEGIN) begin
            r_desired <= clamp_des;
        end
        if (out_load) begin
            r_ox      <= out_point ? pt_res[0] : '0;
            r_oy      <= out_point ? pt_res[1] : '0;
            r_oz      <= out_point ? pt_res[2] : '0;
            r_ofactor <= r_factor;
            r_ostatus <= r_status;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_x_out      = r_ox;
    assign o_y_out      = r_oy;
    assign o_z_out      = r_oz;
    assign o_factor_out = r_ofactor;
    assign o_status     = r_ostatus;

endmodule

/* hdl/vat_lane.sv */
`timescale 1ns / 1ps
// One coordinate lane: two registered products, summed, floor-shifted and saturated.
// Depends on vat_pkg.
module vat_lane #(
    parameter int COORD_FRAC_BITS = vat_pkg::DEF_COORD_FRAC_BITS,
    parameter int TRIG_FRAC_BITS  = vat_pkg::DEF_TRIG_FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic            i_trig,
    input  vat_pkg::t_coord i_a,
    input  vat_pkg::t_coord i_ca,
    input  vat_pkg::t_coord i_b,
    input  vat_pkg::t_coord i_cb,
    output vat_pkg::t_coord o_res
);
    import vat_pkg::*;

    localparam int PROD_W = 2 * COORD_W;

    logic signed [PROD_W-1:0] r_p0;
    logic signed [PROD_W-1:0] r_p1;
    logic                     r_trig;
    logic signed [PROD_W:0]   sum;
    logic signed [PROD_W:0]   shifted;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0   <= PROD_W'(i_a) * PROD_W'(i_ca);
            r_p1   <= PROD_W'(i_b) * PROD_W'(i_cb);
            r_trig <= i_trig;
        end
    end

    always_comb begin
        sum     = {r_p0[PROD_W-1], r_p0} + {r_p1[PROD_W-1], r_p1};
        shifted = r_trig ? (sum >>> TRIG_FRAC_BITS) : (sum >>> COORD_FRAC_BITS);
        if ((&shifted[PROD_W:COORD_W-1]) || !(|shifted[PROD_W:COORD_W-1])) begin
            o_res = shifted[COORD_W-1:0];
        end else begin
            o_res = shifted[PROD_W] ? COORD_MIN : COORD_MAX;
        end
    end

endmodule

/* hdl/vat_merge.sv */
`timescale 1ns / 1ps
// Merging stage: per-lane extents of the bounding box and their registered maximum.
// Depends on vat_pkg.
module vat_merge (
    input  logic            i_clk,
    input  vat_pkg::t_coord i_lo [vat_pkg::LANES],
    input  vat_pkg::t_coord i_hi [vat_pkg::LANES],
    output vat_pkg::t_ext   o_ext
);
    import vat_pkg::*;

    logic signed [COORD_W:0] r_diff [LANES];
    logic signed [COORD_W:0] r_max;
    logic signed [COORD_W:0] max01;
    logic signed [COORD_W:0] max012;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LANES; i++) begin
            r_diff[i] <= {i_hi[i][COORD_W-1], i_hi[i]} - {i_lo[i][COORD_W-1], i_lo[i]};
        end
        r_max <= max012;
    end

    always_comb begin
        max01  = (r_diff[1] > r_diff[0]) ? r_diff[1] : r_diff[0];
        max012 = (r_diff[2] > max01) ? r_diff[2] : max01;
    end

    assign o_ext.zero = (r_max == '0);
    assign o_ext.neg  = r_max[COORD_W];
    assign o_ext.mag  = r_max[COORD_W-1:0];

endmodule

/* hdl/vat_div.sv */
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle.
// Depends on vat_pkg.
module vat_div #(
    parameter int DIVIDEND_W = vat_pkg::FACTOR_W + vat_pkg::DEF_COORD_FRAC_BITS,
    parameter int DIVISOR_W  = vat_pkg::COORD_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quot
);
    import vat_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

/* hdl/vat_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the vertex affine transform, bound to its top level.
// Depends on vat_pkg and vertex_affine_transform.
module vat_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input vat_pkg::t_coord o_x_out,
    input vat_pkg::t_coord o_y_out,
    input vat_pkg::t_coord o_z_out,
    input logic [1:0]      o_status
);
    import vat_pkg::*;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output beat present after reset");

    // Items are handled one at a time, so an accepted beat closes the input.
    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input open in the cycle after an accepted beat");

    // The input stays open while nothing arrives.
    a_idle_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall && !i_valid |=> !o_stall)
        else $error("input closed without an accepted beat");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output beat withdrawn while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_x_out) && $stable(o_y_out)
                               && $stable(o_z_out) && $stable(o_status))
        else $error("output payload changed while stalled");

endmodule

bind vertex_affine_transform vat_checker u_vat_checker (.*);
